FILE: rtl/core/bracket_balance_checker_defines.svh
// ----------------------------------------------------------------------------
// Bracket balance checker assertion macros
// Shared concurrent assertion helpers, clocked on the rising edge and
// disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef BRACKET_BALANCE_CHECKER_DEFINES_SVH
`define BRACKET_BALANCE_CHECKER_DEFINES_SVH

// Generic property check with async active-low reset disable.
`define BBC_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bracket_balance_checker: assertion failed");

// Same-cycle implication.
`define BBC_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  `BBC_ASSERT(name, clk, rst_n, (ante) |-> (cons))

// Next-cycle implication.
`define BBC_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  `BBC_ASSERT(name, clk, rst_n, (ante) |=> (cons))

`endif

FILE: rtl/core/bbc_pkg.sv
// ----------------------------------------------------------------------------
// Bracket balance checker package
// Sizes, character codes, encodings and shared helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bbc_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int COUNT_WIDTH = 16;
  localparam int LEVEL_W     = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W       = $clog2(STACK_DEPTH);
  localparam int OUT_W       = 16;

  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LSQR   = 8'h5B;
  localparam logic [7:0] CH_RSQR   = 8'h5D;

  typedef enum logic [1:0] {
    BR_NONE   = 2'd0,
    BR_PAREN  = 2'd1,
    BR_BRACE  = 2'd2,
    BR_SQUARE = 2'd3
  } br_e;

  typedef enum logic [1:0] {
    CM_NONE  = 2'd0,
    CM_LINE  = 2'd1,
    CM_BLOCK = 2'd2
  } cmode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MISMATCH = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  typedef logic [COUNT_WIDTH-1:0] cnt_t;
  typedef logic [LEVEL_W-1:0]     level_t;

  typedef struct packed {
    logic push;
    logic pop;
    br_e  code;
  } stk_op_t;

  typedef struct packed {
    level_t level;
    br_e    top;
  } stk_stat_t;

  typedef struct packed {
    status_e          status;
    logic [OUT_W-1:0] line_num;
    logic [OUT_W-1:0] pair_count;
  } result_t;

  function automatic cnt_t sat_inc(cnt_t v);
    return (v == '1) ? v : v + cnt_t'(1);
  endfunction

  function automatic logic [OUT_W-1:0] to_out(cnt_t v);
    logic [31:0] wide;
    wide = 32'(v);
    return wide[OUT_W-1:0];
  endfunction

  function automatic br_e opener_code(logic [7:0] c);
    br_e code;
    case (c)
      CH_LPAREN: code = BR_PAREN;
      CH_LBRACE: code = BR_BRACE;
      CH_LSQR:   code = BR_SQUARE;
      default:   code = BR_NONE;
    endcase
    return code;
  endfunction

  function automatic br_e closer_code(logic [7:0] c);
    br_e code;
    case (c)
      CH_RPAREN: code = BR_PAREN;
      CH_RBRACE: code = BR_BRACE;
      CH_RSQR:   code = BR_SQUARE;
      default:   code = BR_NONE;
    endcase
    return code;
  endfunction

endpackage

FILE: rtl/core/bbc_if.sv
// ----------------------------------------------------------------------------
// Bracket balance checker stream interfaces
// Valid/ready channels for text bytes in and check results out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bbc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       is_last;

  modport source (output valid, output text_byte, output is_last, input ready);
  modport sink   (input valid, input text_byte, input is_last, output ready);
endinterface

interface bbc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] line_num;
  logic [15:0] pair_count;

  modport source (output valid, output status, output line_num,
                  output pair_count, input ready);
  modport sink   (input valid, input status, input line_num,
                  input pair_count, output ready);
endinterface

FILE: rtl/core/bbc_stack.sv
// ----------------------------------------------------------------------------
// Bracket stack
// Top entry in a register, lower entries in a synchronous RAM. The entry
// under the top is read ahead into a register; a push forwards the spilled top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bbc_stack (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                clear_i,
  input  bbc_pkg::stk_op_t    op_i,
  output bbc_pkg::stk_stat_t  stat_o
);

  logic [1:0]                   mem_q [bbc_pkg::STACK_DEPTH];
  logic [1:0]                   rd_q;
  logic [1:0]                   fwd_data_q;
  logic                         fwd_q, fwd_d;
  bbc_pkg::level_t              level_q, level_d;
  bbc_pkg::br_e                 top_q, top_d;
  bbc_pkg::br_e                 below;
  logic                         wr_en;
  logic [bbc_pkg::IDX_W-1:0]    wr_addr, rd_addr;
  bbc_pkg::level_t              lvl_m1, lvl_m2;

  assign below = bbc_pkg::br_e'(fwd_q ? fwd_data_q : rd_q);

  always_comb begin
    level_d = level_q;
    top_d   = top_q;
    wr_en   = 1'b0;
    if (op_i.push) begin
      level_d = level_q + bbc_pkg::level_t'(1);
      top_d   = op_i.code;
      wr_en   = (level_q != '0);
    end else if (op_i.pop) begin
      level_d = level_q - bbc_pkg::level_t'(1);
      top_d   = below;
    end
    lvl_m1  = level_q - bbc_pkg::level_t'(1);
    lvl_m2  = level_d - bbc_pkg::level_t'(2);
    wr_addr = lvl_m1[bbc_pkg::IDX_W-1:0];
    rd_addr = lvl_m2[bbc_pkg::IDX_W-1:0];
    // a push reads back the slot it writes
    fwd_d   = wr_en;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
      fwd_q   <= 1'b0;
    end else if (clear_i) begin
      level_q <= '0;
      fwd_q   <= 1'b0;
    end else begin
      level_q <= level_d;
      fwd_q   <= fwd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q      <= top_d;
    fwd_data_q <= top_q;
    rd_q       <= mem_q[rd_addr];
    if (wr_en) begin
      mem_q[wr_addr] <= top_q;
    end
  end

  assign stat_o.level = level_q;
  assign stat_o.top   = top_q;

endmodule

FILE: rtl/core/bbc_parser.sv
// ----------------------------------------------------------------------------
// Bracket parser
// Comment/quote tracking, counters and error state; issues stack ops and
// forms the result from the post-step state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bbc_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic                clear_i,
  input  logic [7:0]          char_i,
  input  logic [7:0]          nx_char_i,
  input  logic                nx_valid_i,
  input  bbc_pkg::stk_stat_t  stk_i,
  output bbc_pkg::stk_op_t    op_o,
  output bbc_pkg::result_t    result_o
);

  bbc_pkg::cmode_e  mode_q, mode_d;
  logic             quote_q, quote_d;
  bbc_pkg::cnt_t    nl_q, nl_d;
  bbc_pkg::cnt_t    pair_q, pair_d;
  bbc_pkg::status_e err_q, err_d;
  bbc_pkg::br_e     open_c, close_c;
  bbc_pkg::level_t  lvl_after;
  logic             full;

  assign open_c  = bbc_pkg::opener_code(char_i);
  assign close_c = bbc_pkg::closer_code(char_i);
  assign full    = (stk_i.level == bbc_pkg::level_t'(bbc_pkg::STACK_DEPTH));

  always_comb begin
    mode_d  = mode_q;
    quote_d = quote_q;
    nl_d    = nl_q;
    pair_d  = pair_q;
    err_d   = err_q;
    op_o    = '{push: 1'b0, pop: 1'b0, code: bbc_pkg::BR_NONE};
    if (step_i && (err_q == bbc_pkg::ST_OK)) begin
      if ((char_i == bbc_pkg::CH_SLASH) && !quote_q) begin
        if (nx_valid_i && (nx_char_i == bbc_pkg::CH_SLASH)) begin
          mode_d = bbc_pkg::CM_LINE;
        end else if (nx_valid_i && (nx_char_i == bbc_pkg::CH_STAR)) begin
          mode_d = bbc_pkg::CM_BLOCK;
        end
      end else if (char_i == bbc_pkg::CH_STAR) begin
        if (nx_valid_i && (nx_char_i == bbc_pkg::CH_SLASH)) begin
          mode_d = bbc_pkg::CM_NONE;
        end
      end else if (char_i == bbc_pkg::CH_NL) begin
        nl_d = bbc_pkg::sat_inc(nl_q);
        if (mode_q == bbc_pkg::CM_LINE) begin
          mode_d = bbc_pkg::CM_NONE;
        end
      end else if (mode_q != bbc_pkg::CM_NONE) begin
        // inside a comment
      end else if (char_i == bbc_pkg::CH_QUOTE) begin
        quote_d = !quote_q;
      end else if (quote_q) begin
        // inside a string
      end else if (open_c != bbc_pkg::BR_NONE) begin
        if (full) begin
          err_d = bbc_pkg::ST_OVERFLOW;
        end else begin
          op_o.push = 1'b1;
          op_o.code = open_c;
        end
      end else if (close_c != bbc_pkg::BR_NONE) begin
        if ((stk_i.level != '0) && (stk_i.top == close_c)) begin
          op_o.pop = 1'b1;
          pair_d   = bbc_pkg::sat_inc(pair_q);
        end else begin
          nl_d  = bbc_pkg::sat_inc(nl_q);
          err_d = bbc_pkg::ST_MISMATCH;
        end
      end
    end
  end

  always_comb begin
    lvl_after = stk_i.level;
    if (op_o.push) begin
      lvl_after = stk_i.level + bbc_pkg::level_t'(1);
    end else if (op_o.pop) begin
      lvl_after = stk_i.level - bbc_pkg::level_t'(1);
    end
    if (err_d != bbc_pkg::ST_OK) begin
      result_o.status = err_d;
    end else if (lvl_after != '0) begin
      result_o.status = bbc_pkg::ST_MISMATCH;
    end else begin
      result_o.status = bbc_pkg::ST_OK;
    end
    result_o.line_num   = bbc_pkg::to_out(nl_d);
    result_o.pair_count = bbc_pkg::to_out(pair_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= bbc_pkg::CM_NONE;
      quote_q <= 1'b0;
      nl_q    <= '0;
      pair_q  <= '0;
      err_q   <= bbc_pkg::ST_OK;
    end else if (clear_i) begin
      mode_q  <= bbc_pkg::CM_NONE;
      quote_q <= 1'b0;
      nl_q    <= '0;
      pair_q  <= '0;
      err_q   <= bbc_pkg::ST_OK;
    end else begin
      mode_q  <= mode_d;
      quote_q <= quote_d;
      nl_q    <= nl_d;
      pair_q  <= pair_d;
      err_q   <= err_d;
    end
  end

endmodule

FILE: rtl/core/bracket_balance_checker.sv
// Result: the last byte is finished once the output slot is free, later only
//   while the previous result waits; the result is then registered.
// Throughput: one byte per cycle, except that input is held off while the
//   last byte of a text waits to be finished without lookahead.
// Reset: async active low; clears modes, counters, stack level and
//   handshake state. Stack RAM contents are not cleared.
// ----------------------------------------------------------------------------
// Bracket balance checker, top level
// Streams source text, tracks comments and strings, checks (), {} and []
// nesting on a RAM-backed stack and reports one result per text.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bracket_balance_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  bbc_in_if.sink         txt_i,
  bbc_out_if.source      res_o
);

  // Byte hold: each byte but a text's last is judged when the next byte
  // arrives, which serves as lookahead for the two-character comment markers.
  logic             hold_valid_q;
  logic [7:0]       hold_char_q;

  // Final byte of a text waits here for its own (lookahead-free) step.
  logic             last_pend_q;
  logic [7:0]       last_char_q;

  // Output register decouples the result from the input side.
  logic             out_valid_q;
  bbc_pkg::result_t out_q;

  logic             in_xfer;
  logic             out_free;
  logic             fin;
  logic             step;
  logic [7:0]       step_char;

  bbc_pkg::stk_op_t   stk_op;
  bbc_pkg::stk_stat_t stk_stat;
  bbc_pkg::result_t   result;

  assign txt_i.ready = !last_pend_q;
  assign in_xfer     = txt_i.valid && txt_i.ready;
  assign out_free    = !out_valid_q || res_o.ready;

  // Finish a text once the output slot is free; stalls input meanwhile.
  assign fin       = last_pend_q && out_free;
  // A held byte is processed when its successor arrives.
  assign step      = fin || (in_xfer && hold_valid_q);
  assign step_char = fin ? last_char_q : hold_char_q;

  bbc_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .clear_i    (fin),
    .char_i     (step_char),
    .nx_char_i  (txt_i.text_byte),
    .nx_valid_i (!fin),
    .stk_i      (stk_stat),
    .op_o       (stk_op),
    .result_o   (result)
  );

  bbc_stack u_stack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (fin),
    .op_i    (stk_op),
    .stat_o  (stk_stat)
  );

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
      last_pend_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (in_xfer) begin
        hold_valid_q <= !txt_i.is_last;
        last_pend_q  <= txt_i.is_last;
      end else if (fin) begin
        last_pend_q  <= 1'b0;
      end
      if (fin) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      hold_char_q <= txt_i.text_byte;
      last_char_q <= txt_i.text_byte;
    end
    if (fin) begin
      out_q <= result;
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.status     = out_q.status;
  assign res_o.line_num   = out_q.line_num;
  assign res_o.pair_count = out_q.pair_count;

endmodule

FILE: rtl/core/bbc_checker.sv
// ----------------------------------------------------------------------------
// Bracket balance checker port assertions
// Watches the top-level channels and is bound to every instance.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bracket_balance_checker_defines.svh"

module bbc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        in_last_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  out_status_i,
  input logic [15:0] out_line_i,
  input logic [15:0] out_pair_i
);

  // A stalled result holds.
  `BBC_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable({out_status_i, out_line_i, out_pair_i}))

  // The input is closed in the cycle after the last byte's transfer.
  `BBC_ASSERT_NXT(a_last_stall, clk_i, rst_ni, in_valid_i && in_ready_i && in_last_i, !in_ready_i)

  // A new result only appears after input was held off for the final byte.
  `BBC_ASSERT_IMP(a_res_after_last, clk_i, rst_ni, $rose(out_valid_i), !$past(in_ready_i))

  // Status is one of ok, mismatch, overflow.
  `BBC_ASSERT_IMP(a_status_code, clk_i, rst_ni, out_valid_i, out_status_i != 2'd3)

endmodule

bind bracket_balance_checker bbc_checker u_bbc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (txt_i.valid),
  .in_ready_i   (txt_i.ready),
  .in_last_i    (txt_i.is_last),
  .out_valid_i  (res_o.valid),
  .out_ready_i  (res_o.ready),
  .out_status_i (res_o.status),
  .out_line_i   (res_o.line_num),
  .out_pair_i   (res_o.pair_count)
);
